### design/pwbs_pkg.sv
// pwbs_pkg: shared types, constants and helpers for the one-wire byte sender.
// No dependencies; used by every module in the design folder.
package pwbs_pkg;

  localparam int QueueDepth    = 4;
  localparam int DataWidth     = 8;
  localparam int TickWidth     = 16;
  localparam int CfgIndexWidth = 8;
  localparam int NumBits       = 8;
  localparam int BitCountWidth = 4;

  // register indexes on the configuration channel
  localparam logic [CfgIndexWidth-1:0] CfgStartHigh = CfgIndexWidth'(0);
  localparam logic [CfgIndexWidth-1:0] CfgStartLow  = CfgIndexWidth'(1);
  localparam logic [CfgIndexWidth-1:0] CfgLong      = CfgIndexWidth'(2);
  localparam logic [CfgIndexWidth-1:0] CfgShort     = CfgIndexWidth'(3);

  localparam logic [TickWidth-1:0] StartHighReset = TickWidth'(1000);
  localparam logic [TickWidth-1:0] StartLowReset  = TickWidth'(3000);
  localparam logic [TickWidth-1:0] LongReset      = TickWidth'(600);
  localparam logic [TickWidth-1:0] ShortReset     = TickWidth'(200);

  typedef enum logic {
    OP_TICK,
    OP_LOAD
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [DataWidth-1:0] data;
  } item_t;

  typedef struct packed {
    logic [TickWidth-1:0] start_high_ticks;
    logic [TickWidth-1:0] start_low_ticks;
    logic [TickWidth-1:0] long_ticks;
    logic [TickWidth-1:0] short_ticks;
  } cfg_regs_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_status_t;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_START_HIGH = 3'd1,
    PH_START_LOW  = 3'd2,
    PH_BIT_HIGH   = 3'd3,
    PH_BIT_LOW    = 3'd4
  } phase_t;

  // a duration of zero counts as one tick
  function automatic logic [TickWidth-1:0] at_least_one(input logic [TickWidth-1:0] v);
    at_least_one = (v == '0) ? TickWidth'(1) : v;
  endfunction

endpackage

### design/pwbs_front.sv
// pwbs_front: input stage; takes beats, classifies tick vs load, feeds the queue.
// Depends on pwbs_pkg.
module pwbs_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic                          command,
  input  logic [pwbs_pkg::DataWidth-1:0] data_byte,
  input  pwbs_pkg::q_status_t           q_status,
  output logic                          push,
  output pwbs_pkg::item_t               push_item
);

  logic            held;
  pwbs_pkg::item_t held_item;
  logic            take;

  assign push       = held && !q_status.full;
  assign push_item  = held_item;
  assign item_stall = held && q_status.full;
  assign take       = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_item.op   <= command ? pwbs_pkg::OP_LOAD : pwbs_pkg::OP_TICK;
      // data only matters for a load
      held_item.data <= command ? data_byte : '0;
    end
  end

endmodule

### design/pwbs_queue.sv
// pwbs_queue: small FIFO between the front stage and the line engine.
// Depends on pwbs_pkg.
module pwbs_queue #(
  parameter int Depth = pwbs_pkg::QueueDepth
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  pwbs_pkg::item_t     push_item,
  input  logic                pop,
  output pwbs_pkg::item_t     head_item,
  output pwbs_pkg::q_status_t status
);

  localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CountWidth = $clog2(Depth + 1);

  pwbs_pkg::item_t         mem [Depth];
  logic [PtrWidth-1:0]     wr_ptr;
  logic [PtrWidth-1:0]     rd_ptr;
  logic [CountWidth-1:0]   count;
  logic                    do_push;
  logic                    do_pop;

  assign status.full      = (count == CountWidth'(Depth));
  assign status.not_empty = (count != '0);
  assign do_push          = push && !status.full;
  assign do_pop           = pop && status.not_empty;
  assign head_item        = mem[rd_ptr];

  function automatic logic [PtrWidth-1:0] wrap_inc(input logic [PtrWidth-1:0] p);
    wrap_inc = (p == PtrWidth'(Depth - 1)) ? '0 : p + PtrWidth'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + CountWidth'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CountWidth'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

### design/pwbs_back.sv
// pwbs_back: line engine; phase sequencer, tick counter, bit shifter, result register.
// Depends on pwbs_pkg.
module pwbs_back (
  input  logic                clk,
  input  logic                rst,
  input  pwbs_pkg::cfg_regs_t cfg,
  input  pwbs_pkg::q_status_t q_status,
  input  pwbs_pkg::item_t     head_item,
  output logic                pop,
  output logic                res_valid,
  input  logic                res_stall,
  output logic                line_level,
  output logic                busy_res,
  output logic                load_rejected,
  output logic                frame_done
);

  localparam int TW = pwbs_pkg::TickWidth;
  localparam int BW = pwbs_pkg::BitCountWidth;
  localparam int DW = pwbs_pkg::DataWidth;

  pwbs_pkg::phase_t phase;
  pwbs_pkg::phase_t phase_next;
  logic [TW-1:0]    ticks_left;
  logic [TW-1:0]    ticks_left_next;
  logic [DW-1:0]    shift_byte;
  logic [DW-1:0]    shift_byte_next;
  logic [BW-1:0]    bits_sent;
  logic [BW-1:0]    bits_sent_next;
  logic [BW-1:0]    bits_inc;
  logic             line_out;
  logic             line_out_next;
  logic             busy;
  logic             busy_next;
  logic             rejected;
  logic             done;

  // next beat may enter while the result register is empty or draining
  assign pop      = q_status.not_empty && (!res_valid || !res_stall);
  assign bits_inc = bits_sent + BW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= pwbs_pkg::PH_IDLE;
      ticks_left <= '0;
      shift_byte <= '0;
      bits_sent  <= '0;
      line_out   <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (pop) begin
        phase      <= phase_next;
        ticks_left <= ticks_left_next;
        shift_byte <= shift_byte_next;
        bits_sent  <= bits_sent_next;
        line_out   <= line_out_next;
        res_valid  <= 1'b1;
      end else if (!res_stall) begin
        res_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      line_level    <= line_out_next;
      busy_res      <= busy_next;
      load_rejected <= rejected;
      frame_done    <= done;
    end
  end

  always_comb begin
    phase_next      = phase;
    ticks_left_next = ticks_left;
    shift_byte_next = shift_byte;
    bits_sent_next  = bits_sent;
    line_out_next   = line_out;
    rejected        = 1'b0;
    done            = 1'b0;
    busy = (phase == pwbs_pkg::PH_START_HIGH) || (phase == pwbs_pkg::PH_START_LOW) ||
           (phase == pwbs_pkg::PH_BIT_HIGH) || (phase == pwbs_pkg::PH_BIT_LOW);

    if (head_item.op == pwbs_pkg::OP_LOAD) begin
      if (busy) begin
        rejected = 1'b1;
      end else begin
        shift_byte_next = head_item.data;
        bits_sent_next  = '0;
        phase_next      = pwbs_pkg::PH_START_HIGH;
        line_out_next   = 1'b1;
        ticks_left_next = pwbs_pkg::at_least_one(cfg.start_high_ticks);
      end
    end else if (busy) begin
      if (ticks_left > TW'(1)) begin
        ticks_left_next = ticks_left - TW'(1);
      end else begin
        unique case (phase)
          pwbs_pkg::PH_START_HIGH: begin
            phase_next      = pwbs_pkg::PH_START_LOW;
            line_out_next   = 1'b0;
            ticks_left_next = pwbs_pkg::at_least_one(cfg.start_low_ticks);
          end
          pwbs_pkg::PH_START_LOW: begin
            phase_next      = pwbs_pkg::PH_BIT_HIGH;
            line_out_next   = 1'b1;
            ticks_left_next = pwbs_pkg::at_least_one(shift_byte[0] ? cfg.long_ticks
                                                                    : cfg.short_ticks);
          end
          pwbs_pkg::PH_BIT_HIGH: begin
            phase_next      = pwbs_pkg::PH_BIT_LOW;
            line_out_next   = 1'b0;
            ticks_left_next = pwbs_pkg::at_least_one(shift_byte[0] ? cfg.short_ticks
                                                                    : cfg.long_ticks);
          end
          pwbs_pkg::PH_BIT_LOW: begin
            shift_byte_next = shift_byte >> 1;
            bits_sent_next  = bits_inc;
            if (bits_inc >= BW'(pwbs_pkg::NumBits)) begin
              phase_next      = pwbs_pkg::PH_IDLE;
              line_out_next   = 1'b1;
              ticks_left_next = '0;
              done            = 1'b1;
            end else begin
              // next bit starts from the freshly shifted byte
              phase_next      = pwbs_pkg::PH_BIT_HIGH;
              line_out_next   = 1'b1;
              ticks_left_next = pwbs_pkg::at_least_one(shift_byte[1] ? cfg.long_ticks
                                                                      : cfg.short_ticks);
            end
          end
          default: begin
          end
        endcase
      end
    end

    busy_next = (phase_next == pwbs_pkg::PH_START_HIGH) ||
                (phase_next == pwbs_pkg::PH_START_LOW) ||
                (phase_next == pwbs_pkg::PH_BIT_HIGH) ||
                (phase_next == pwbs_pkg::PH_BIT_LOW);
  end

endmodule

### design/pulse_width_one_wire_byte_sender.sv
// Sends one byte LSB first on a single line as pulse-width coded bits: a start
// pulse (high, then low), then eight bits, each a high phase and a low phase,
// long/short for a one and short/long for a zero. The line rests high after a frame.
// Item channel (item_valid/item_stall): command 0 is one time tick, 1 loads
// data_byte. A load during a frame is dropped and flagged in load_rejected.
// Result channel (res_valid/res_stall): exactly one result per item, in order:
// line level and busy after the item, the reject flag, and frame_done on the
// tick that closes a frame.
// Configuration channel (cfg_valid/cfg_ready, always ready): index 0..3 selects
// start high, start low, long and short durations in ticks; other indexes are
// ignored; a duration of 0 acts as 1. Write only while no item is in flight.
// A result is registered after its item passes the input register and the queue
// into the result register. Throughput is one item per cycle while the result
// register is not stalled, set by the phase/counter step in the engine; a stalled
// result register backs up the queue and then the input stage.
// Reset: internal line state low (line_level is not reset), idle, durations 1000/3000/600/200 ticks.
module pulse_width_one_wire_byte_sender #(
  parameter int QueueDepth = pwbs_pkg::QueueDepth
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic                              command,
  input  logic [pwbs_pkg::DataWidth-1:0]     data_byte,
  output logic                              res_valid,
  input  logic                              res_stall,
  output logic                              line_level,
  output logic                              busy_res,
  output logic                              load_rejected,
  output logic                              frame_done,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pwbs_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [pwbs_pkg::TickWidth-1:0]     cfg_data
);

  pwbs_pkg::cfg_regs_t cfg;
  pwbs_pkg::q_status_t q_status;
  pwbs_pkg::item_t     push_item;
  pwbs_pkg::item_t     head_item;
  logic                push;
  logic                pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_high_ticks <= pwbs_pkg::StartHighReset;
      cfg.start_low_ticks  <= pwbs_pkg::StartLowReset;
      cfg.long_ticks       <= pwbs_pkg::LongReset;
      cfg.short_ticks      <= pwbs_pkg::ShortReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pwbs_pkg::CfgStartHigh: cfg.start_high_ticks <= cfg_data;
        pwbs_pkg::CfgStartLow:  cfg.start_low_ticks  <= cfg_data;
        pwbs_pkg::CfgLong:      cfg.long_ticks       <= cfg_data;
        pwbs_pkg::CfgShort:     cfg.short_ticks      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pwbs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .command    (command),
    .data_byte  (data_byte),
    .q_status   (q_status),
    .push       (push),
    .push_item  (push_item)
  );

  pwbs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .status    (q_status)
  );

  pwbs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_status      (q_status),
    .head_item     (head_item),
    .pop           (pop),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .line_level    (line_level),
    .busy_res      (busy_res),
    .load_rejected (load_rejected),
    .frame_done    (frame_done)
  );

endmodule
